@@ hw/rtl/bltab_pkg.sv @@
// shared types and codes for the bounded list table
package bltab_pkg;

  localparam int unsigned CMD_W      = 4;
  localparam int unsigned NARROW_W   = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned WORD_PORT_W = 64;

  localparam logic [NARROW_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 4'd0,
    CMD_PUSH_UNIQ = 4'd1,
    CMD_POP       = 4'd2,
    CMD_INSERT    = 4'd3,
    CMD_REMOVE    = 4'd4,
    CMD_GET       = 4'd5,
    CMD_SET       = 4'd6,
    CMD_FIND      = 4'd7,
    CMD_COUNT     = 4'd8,
    CMD_REM_ALL   = 4'd9,
    CMD_REM_FIRST = 4'd10,
    CMD_CLEAR     = 4'd11
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BOUNDS    = 3'd3,
    STAT_EXISTS    = 3'd4,
    STAT_NOT_FOUND = 3'd5
  } status_e;

  // what one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

endpackage

@@ hw/rtl/bltab_cell.sv @@
// one list slot: word register, neighbour hand-off and local compare
module bltab_cell #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                    clk_i,
  input  bltab_pkg::cell_op_e     op_i,
  input  logic [WORD_BITS-1:0]    word_i,
  input  logic [WORD_BITS-1:0]    left_i,
  input  logic [WORD_BITS-1:0]    right_i,
  output logic [WORD_BITS-1:0]    slot_o,
  output logic                    hit_o
);

  logic [WORD_BITS-1:0] slot_q, slot_d;

  always_comb begin
    case (op_i)
      bltab_pkg::CELL_LOAD:       slot_d = word_i;
      bltab_pkg::CELL_FROM_LEFT:  slot_d = left_i;
      bltab_pkg::CELL_FROM_RIGHT: slot_d = right_i;
      default:                    slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;
  assign hit_o  = (slot_q == word_i);

endmodule

@@ hw/rtl/bounded_list_table_top.sv @@
// bounded list table: ordered word list held in a row of shifting cells
// An ordered list of up to DEPTH words, limited further by the capacity
// register (values above DEPTH act as DEPTH; lowering it never drops held
// entries). Each slot is a cell that compares its word against the request
// word and can take its left or right neighbour's word, so insert and
// remove shift the whole tail of the list together. A word is latched on
// acceptance and executed in the exec state: push, pop, insert, remove,
// get, set and clear place their result in the output register in their
// first execution step and then return to idle.
// Find, push unique, count, remove first and remove all walk a scan index
// over the held entries, one entry per cycle while the output register is
// free, and place their result on a match or at the end of the list (count
// and remove all only at the end); remove all stays on an index after
// removing a match there. The next request is taken once the result has
// been placed in the output register, which parts the two sides; the
// execution steps pause while that register still holds an untaken word.
// Clear only resets the fill count: slots at or beyond fill are never read.
module bounded_list_table_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request side
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [bltab_pkg::CMD_W-1:0]          cmd_i,
  input  logic [bltab_pkg::NARROW_W-1:0]       position_i,
  input  logic [bltab_pkg::WORD_PORT_W-1:0]    word_in_i,
  // result side
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [bltab_pkg::STATUS_W-1:0]       status_o,
  output logic [bltab_pkg::WORD_PORT_W-1:0]    word_out_o,
  output logic [bltab_pkg::NARROW_W-1:0]       found_at_o,
  output logic [bltab_pkg::NARROW_W-1:0]       match_total_o,
  output logic [bltab_pkg::NARROW_W-1:0]       size_now_o,
  // capacity register write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bltab_pkg::NARROW_W-1:0]       cfg_data_i
);

  // count width, slot index width, and a common width for comparisons
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW = (CW > bltab_pkg::NARROW_W) ? CW : bltab_pkg::NARROW_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                          state_q;
  bltab_pkg::cmd_e                 cmd_q;
  logic [bltab_pkg::NARROW_W-1:0]  pos_q;
  logic [WORD_BITS-1:0]            word_q;
  logic [CW-1:0]                   fill_q, fill_d;
  logic [CW-1:0]                   scan_q, scan_d;   // scan index
  logic [CW-1:0]                   acc_q, acc_d;     // match / removal tally
  logic [bltab_pkg::NARROW_W-1:0]  cap_q;

  // output register
  logic                            out_valid_q;
  bltab_pkg::status_e              status_q;
  logic [WORD_BITS-1:0]            rd_word_q;
  logic [CW-1:0]                   found_q;
  logic [CW-1:0]                   total_q;
  logic [CW-1:0]                   size_q;

  // row of cells
  logic [WORD_BITS-1:0]            slot   [DEPTH];
  logic [DEPTH-1:0]                hit;
  bltab_pkg::cell_op_e             cell_op [DEPTH];

  // step decisions
  logic                            out_free, step_en, commit;
  bltab_pkg::status_e              status_d;
  logic [WORD_BITS-1:0]            rd_word_d;
  logic [CW-1:0]                   found_d, total_d;
  logic                            do_wr, do_shr, do_shl;
  logic [MW-1:0]                   op_idx;
  logic [MW-1:0]                   rd_idx;
  logic [WORD_BITS-1:0]            rd_sel;
  logic [MW-1:0]                   pos_m, fill_m, scan_m, cap_m;
  logic                            scan_done, cur_hit, is_full;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step_en  = (state_q == ST_EXEC) && out_free;

  assign pos_m  = MW'(pos_q);
  assign fill_m = MW'(fill_q);
  assign scan_m = MW'(scan_q);
  // capacity clamped to the table depth
  assign cap_m  = (MW'(cap_q) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(cap_q);

  assign is_full   = (fill_m >= cap_m);
  assign scan_done = (scan_q >= fill_q);
  assign cur_hit   = !scan_done && hit[scan_q[IW-1:0]];

  // one read port into the row, for pop, remove and get
  assign rd_idx = (cmd_q == bltab_pkg::CMD_POP) ? (fill_m - MW'(1)) : pos_m;
  assign rd_sel = slot[rd_idx[IW-1:0]];

  always_comb begin
    commit    = 1'b0;
    status_d  = bltab_pkg::STAT_OK;
    rd_word_d = '0;
    found_d   = '0;
    total_d   = '0;
    fill_d    = fill_q;
    scan_d    = scan_q;
    acc_d     = acc_q;
    do_wr     = 1'b0;
    do_shr    = 1'b0;
    do_shl    = 1'b0;
    op_idx    = '0;
    if (step_en) begin
      case (cmd_q)
        bltab_pkg::CMD_PUSH: begin
          commit = 1'b1;
          if (is_full) begin
            status_d = bltab_pkg::STAT_FULL;
          end else begin
            do_wr  = 1'b1;
            op_idx = fill_m;
            fill_d = fill_q + CW'(1);
          end
        end
        bltab_pkg::CMD_PUSH_UNIQ: begin
          if (cur_hit) begin
            commit   = 1'b1;
            status_d = bltab_pkg::STAT_EXISTS;
          end else if (!scan_done) begin
            scan_d = scan_q + CW'(1);
          end else begin
            commit = 1'b1;
            if (is_full) begin
              status_d = bltab_pkg::STAT_FULL;
            end else begin
              do_wr  = 1'b1;
              op_idx = fill_m;
              fill_d = fill_q + CW'(1);
            end
          end
        end
        bltab_pkg::CMD_POP: begin
          commit = 1'b1;
          if (fill_q == '0) begin
            status_d = bltab_pkg::STAT_EMPTY;
          end else begin
            rd_word_d = rd_sel;
            fill_d    = fill_q - CW'(1);
          end
        end
        bltab_pkg::CMD_INSERT: begin
          commit = 1'b1;
          if (pos_m > fill_m) begin
            status_d = bltab_pkg::STAT_BOUNDS;
          end else if (is_full) begin
            status_d = bltab_pkg::STAT_FULL;
          end else begin
            do_shr = 1'b1;
            op_idx = pos_m;
            fill_d = fill_q + CW'(1);
          end
        end
        bltab_pkg::CMD_REMOVE: begin
          commit = 1'b1;
          if (pos_m >= fill_m) begin
            status_d = bltab_pkg::STAT_BOUNDS;
          end else begin
            rd_word_d = rd_sel;
            do_shl    = 1'b1;
            op_idx    = pos_m;
            fill_d    = fill_q - CW'(1);
          end
        end
        bltab_pkg::CMD_GET: begin
          commit = 1'b1;
          if (pos_m >= fill_m) begin
            status_d = bltab_pkg::STAT_BOUNDS;
          end else begin
            rd_word_d = rd_sel;
          end
        end
        bltab_pkg::CMD_SET: begin
          commit = 1'b1;
          if (pos_m >= fill_m) begin
            status_d = bltab_pkg::STAT_BOUNDS;
          end else begin
            do_wr  = 1'b1;
            op_idx = pos_m;
          end
        end
        bltab_pkg::CMD_FIND: begin
          if (cur_hit) begin
            commit  = 1'b1;
            found_d = scan_q;
          end else if (!scan_done) begin
            scan_d = scan_q + CW'(1);
          end else begin
            commit   = 1'b1;
            status_d = bltab_pkg::STAT_NOT_FOUND;
          end
        end
        bltab_pkg::CMD_COUNT: begin
          if (!scan_done) begin
            scan_d = scan_q + CW'(1);
            acc_d  = acc_q + CW'(cur_hit);
          end else begin
            commit  = 1'b1;
            total_d = acc_q;
          end
        end
        bltab_pkg::CMD_REM_ALL: begin
          if (cur_hit) begin
            // close the gap and look at the same index again
            do_shl = 1'b1;
            op_idx = scan_m;
            fill_d = fill_q - CW'(1);
            acc_d  = acc_q + CW'(1);
          end else if (!scan_done) begin
            scan_d = scan_q + CW'(1);
          end else begin
            commit  = 1'b1;
            total_d = acc_q;
          end
        end
        bltab_pkg::CMD_REM_FIRST: begin
          if (cur_hit) begin
            commit = 1'b1;
            do_shl = 1'b1;
            op_idx = scan_m;
            fill_d = fill_q - CW'(1);
          end else if (!scan_done) begin
            scan_d = scan_q + CW'(1);
          end else begin
            commit   = 1'b1;
            status_d = bltab_pkg::STAT_NOT_FOUND;
          end
        end
        bltab_pkg::CMD_CLEAR: begin
          commit = 1'b1;
          fill_d = '0;
        end
        default: begin
          commit = 1'b1;
        end
      endcase
    end
  end

  // per-cell moves from the broadcast decision
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    localparam int unsigned CI = gi;
    logic [WORD_BITS-1:0] left_w, right_w;

    if (gi == 0) begin : g_first
      assign left_w = word_q;
    end else begin : g_inner_l
      assign left_w = slot[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_w = word_q;
    end else begin : g_inner_r
      assign right_w = slot[gi+1];
    end

    always_comb begin
      cell_op[gi] = bltab_pkg::CELL_HOLD;
      if (do_wr && (op_idx == MW'(CI))) begin
        cell_op[gi] = bltab_pkg::CELL_LOAD;
      end else if (do_shr && (op_idx == MW'(CI))) begin
        cell_op[gi] = bltab_pkg::CELL_LOAD;
      end else if (do_shr && (MW'(CI) > op_idx)) begin
        cell_op[gi] = bltab_pkg::CELL_FROM_LEFT;
      end else if (do_shl && (MW'(CI) >= op_idx) && (CI + 1 < DEPTH)) begin
        cell_op[gi] = bltab_pkg::CELL_FROM_RIGHT;
      end
    end

    bltab_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[gi]),
      .word_i  (word_q),
      .left_i  (left_w),
      .right_i (right_w),
      .slot_o  (slot[gi]),
      .hit_o   (hit[gi])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      scan_q      <= '0;
      acc_q       <= '0;
      cap_q       <= bltab_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
            cmd_q   <= bltab_pkg::cmd_e'(cmd_i);
            pos_q   <= position_i;
            word_q  <= word_in_i[WORD_BITS-1:0];
            scan_q  <= '0;
            acc_q   <= '0;
          end
        end
        ST_EXEC: begin
          scan_q <= scan_d;
          acc_q  <= acc_d;
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        rd_word_q   <= rd_word_d;
        found_q     <= found_d;
        total_q     <= total_d;
        size_q      <= fill_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign word_out_o    = bltab_pkg::WORD_PORT_W'(rd_word_q);
  assign found_at_o    = bltab_pkg::NARROW_W'(found_q);
  assign match_total_o = bltab_pkg::NARROW_W'(total_q);
  assign size_now_o    = bltab_pkg::NARROW_W'(size_q);

endmodule

@@ tb/sv/testbench.sv @@
// self-checking bench for the bounded list table: mirrored list, random traffic, result compare
`timescale 1ns / 1ps

module testbench;
  import bltab_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned LIST_WORD_BITS = 64;
  localparam int unsigned SEGMENTS = 9;
  localparam int unsigned ITEMS_PER_SEGMENT = 210;
  // well above what the requests need, even with idling
  localparam int unsigned CYCLE_LIMIT = 400000;
  // idle time after draining, long enough for a scan over a full list
  localparam int unsigned TAIL_CYCLES = 24;

  // command codes outside the defined set, which the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd12;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  // one result word as seen on the output ports
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [WORD_PORT_W-1:0] word;
    logic [NARROW_W-1:0]    found_at;
    logic [NARROW_W-1:0]    match_total;
    logic [NARROW_W-1:0]    size_now;
  } reply_t;

  // mirror of the list contents plus the queue of results still owed by the block
  class list_mirror;
    logic [WORD_PORT_W-1:0] slots[LIST_DEPTH];
    int                     fill;
    logic [NARROW_W-1:0]    capacity;
    reply_t                 awaited_replies[$];
    int                     errors;

    function new();
      for (int i = 0; i < LIST_DEPTH; i++) slots[i] = '0;
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [NARROW_W-1:0] value);
      capacity = value;
    endfunction

    function int first_hit(logic [WORD_PORT_W-1:0] word);
      for (int i = 0; i < fill; i++) begin
        if (slots[i] == word) return i;
      end
      return fill;
    endfunction

    function void close_gap(int idx);
      for (int i = idx; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
    endfunction

    // applies one command to the mirrored list and returns the result it owes
    function reply_t apply_command(logic [CMD_W-1:0] cmd, logic [NARROW_W-1:0] pos,
                                   logic [WORD_PORT_W-1:0] word);
      reply_t r;
      int     hit;
      int     kept;
      int     room;
      r = '0;
      r.status = STAT_OK;
      room = (capacity > LIST_DEPTH) ? LIST_DEPTH : capacity;
      hit = first_hit(word);
      case (cmd)
        CMD_PUSH, CMD_PUSH_UNIQ: begin
          if (cmd == CMD_PUSH_UNIQ && hit < fill) r.status = STAT_EXISTS;
          else if (fill >= room) r.status = STAT_FULL;
          else begin
            slots[fill] = word;
            fill++;
          end
        end
        CMD_POP: begin
          if (fill == 0) r.status = STAT_EMPTY;
          else begin
            fill--;
            r.word = slots[fill];
          end
        end
        CMD_INSERT: begin
          if (pos > fill) r.status = STAT_BOUNDS;
          else if (fill >= room) r.status = STAT_FULL;
          else begin
            for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = word;
            fill++;
          end
        end
        CMD_REMOVE: begin
          if (pos >= fill) r.status = STAT_BOUNDS;
          else begin
            r.word = slots[pos];
            close_gap(pos);
          end
        end
        CMD_GET: begin
          if (pos >= fill) r.status = STAT_BOUNDS;
          else r.word = slots[pos];
        end
        CMD_SET: begin
          if (pos >= fill) r.status = STAT_BOUNDS;
          else slots[pos] = word;
        end
        CMD_FIND: begin
          if (hit < fill) r.found_at = hit[NARROW_W-1:0];
          else r.status = STAT_NOT_FOUND;
        end
        CMD_COUNT: begin
          for (int i = 0; i < fill; i++) begin
            if (slots[i] == word) r.match_total++;
          end
        end
        CMD_REM_ALL: begin
          kept = 0;
          for (int i = 0; i < fill; i++) begin
            if (slots[i] == word) r.match_total++;
            else begin
              slots[kept] = slots[i];
              kept++;
            end
          end
          fill = kept;
        end
        CMD_REM_FIRST: begin
          if (hit < fill) close_gap(hit);
          else r.status = STAT_NOT_FOUND;
        end
        CMD_CLEAR: begin
          fill = 0;
          for (int i = 0; i < LIST_DEPTH; i++) slots[i] = '0;
        end
        default: begin
        end
      endcase
      r.size_now = fill[NARROW_W-1:0];
      return r;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [NARROW_W-1:0] pos,
                               logic [WORD_PORT_W-1:0] word);
      awaited_replies.push_back(apply_command(cmd, pos, word));
    endfunction

    function void compare_field(string name, logic [WORD_PORT_W-1:0] want,
                                logic [WORD_PORT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d size %0d",
                 $time, got.status, got.size_now);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("word_out", want.word, got.word);
      compare_field("found_at", want.found_at, got.found_at);
      compare_field("match_total", want.match_total, got.match_total);
      compare_field("size_now", want.size_now, got.size_now);
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [CMD_W-1:0]       cmd_i;
  logic [NARROW_W-1:0]    position_i;
  logic [WORD_PORT_W-1:0] word_in_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [STATUS_W-1:0]    status_o;
  logic [WORD_PORT_W-1:0] word_out_o;
  logic [NARROW_W-1:0]    found_at_o;
  logic [NARROW_W-1:0]    match_total_o;
  logic [NARROW_W-1:0]    size_now_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [NARROW_W-1:0]    cfg_data_i;

  list_mirror             mirror;
  int unsigned            sender_idle_pct;
  int unsigned            receiver_idle_pct;
  int unsigned            cycle_count;
  // a few values reused often so that matches, duplicates and purges happen
  logic [WORD_PORT_W-1:0] word_pool[4];

  bounded_list_table_top #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(LIST_WORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .word_in_i    (word_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .word_out_o   (word_out_o),
    .found_at_o   (found_at_o),
    .match_total_o(match_total_o),
    .size_now_o   (size_now_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // every result word taken at a rising edge is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_reply({status_o, word_out_o, found_at_o, match_total_o, size_now_o});
    end
  end

  // presents one request word and holds it until it is taken; starts and ends on a falling edge
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NARROW_W-1:0] pos,
                              input logic [WORD_PORT_W-1:0] word);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i      <= cmd;
    position_i <= pos;
    word_in_i  <= word;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(cmd, pos, word);
    @(negedge clk_i);
  endtask

  // lets every owed result drain so that the block is idle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (mirror.pending() != 0) @(negedge clk_i);
  endtask

  // capacity register write, only issued with the block idle
  task automatic write_capacity(input logic [NARROW_W-1:0] value);
    drain_results();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.set_capacity(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WORD_PORT_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // command mix leans on pushes and inserts so the list keeps some depth
  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return CMD_PUSH;
    if (roll < 28) return CMD_PUSH_UNIQ;
    if (roll < 37) return CMD_POP;
    if (roll < 48) return CMD_INSERT;
    if (roll < 56) return CMD_REMOVE;
    if (roll < 64) return CMD_GET;
    if (roll < 70) return CMD_SET;
    if (roll < 76) return CMD_FIND;
    if (roll < 82) return CMD_COUNT;
    if (roll < 87) return CMD_REM_ALL;
    if (roll < 94) return CMD_REM_FIRST;
    if (roll < 96) return CMD_CLEAR;
    return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  // one random request, mostly well formed against the current mirrored list
  task automatic random_request();
    logic [CMD_W-1:0]       cmd;
    logic [NARROW_W-1:0]    pos;
    logic [WORD_PORT_W-1:0] word;
    int unsigned            roll;
    int                     held;
    held = mirror.fill;
    cmd = pick_command();
    // positions mostly within or just past the held entries, sometimes anywhere
    if ($urandom_range(0, 99) < 80) pos = NARROW_W'($urandom_range(0, held));
    else pos = NARROW_W'($urandom_range(0, 31));
    // words: a held value for hits, the shared pool for duplicates, or fully random
    roll = $urandom_range(0, 99);
    if (roll < 30 && held > 0) word = mirror.slots[$urandom_range(0, held - 1)];
    else if (roll < 75) word = word_pool[$urandom_range(0, 3)];
    else word = random_word();
    send_request(cmd, pos, word);
  endtask

  function automatic logic [NARROW_W-1:0] capacity_for_segment(int seg);
    case (seg)
      0: return 5'd16;
      1: return 5'd0;
      2: return 5'd31;
      3: return 5'd5;
      4: return 5'd1;
      5: return 5'd17;
      6: return 5'd8;
      7: return 5'd16;
      default: return 5'd2;
    endcase
  endfunction

  localparam logic [WORD_PORT_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_PORT_W-1:0] ALL_ZEROS = '0;
  localparam logic [WORD_PORT_W-1:0] PATTERN_A = 64'h0123_4567_89ab_cdef;
  localparam logic [WORD_PORT_W-1:0] PATTERN_B = 64'hfedc_ba98_7654_3210;

  initial begin
    mirror = new();
    sender_idle_pct   = 21;
    receiver_idle_pct = 53;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_PUSH;
    position_i  = '0;
    word_in_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part: empty list errors first
    send_request(CMD_POP, 5'd0, ALL_ZEROS);
    send_request(CMD_GET, 5'd0, ALL_ZEROS);
    send_request(CMD_FIND, 5'd0, ALL_ZEROS);
    send_request(CMD_COUNT, 5'd0, ALL_ONES);
    // field extremes, duplicate rejection
    send_request(CMD_PUSH, 5'd0, ALL_ONES);
    send_request(CMD_PUSH, 5'd31, ALL_ZEROS);
    send_request(CMD_PUSH_UNIQ, 5'd0, ALL_ONES);
    send_request(CMD_PUSH_UNIQ, 5'd0, PATTERN_A);
    // insert at the head, at the tail, and past the tail
    send_request(CMD_INSERT, 5'd0, PATTERN_B);
    send_request(CMD_INSERT, 5'd4, PATTERN_A);
    send_request(CMD_INSERT, 5'd6, PATTERN_B);
    send_request(CMD_INSERT, 5'd31, PATTERN_B);
    // overwrite, out-of-range overwrite, reads and searches
    send_request(CMD_SET, 5'd1, ALL_ONES);
    send_request(CMD_SET, 5'd16, ALL_ONES);
    send_request(CMD_GET, 5'd4, ALL_ZEROS);
    send_request(CMD_FIND, 5'd0, ALL_ONES);
    send_request(CMD_COUNT, 5'd0, ALL_ONES);
    send_request(CMD_REM_ALL, 5'd0, ALL_ONES);
    send_request(CMD_REMOVE, 5'd0, ALL_ZEROS);
    send_request(CMD_REM_FIRST, 5'd0, ALL_ZEROS);
    send_request(CMD_REM_FIRST, 5'd0, ALL_ZEROS);
    // undefined command codes leave everything alone
    send_request(CMD_UNUSED_LO, 5'd31, ALL_ONES);
    send_request(CMD_UNUSED_HI, 5'd0, ALL_ONES);
    send_request(CMD_CLEAR, 5'd0, ALL_ZEROS);

    // small capacity: full reporting, and bounds taking precedence over full
    write_capacity(5'd2);
    send_request(CMD_PUSH, 5'd0, PATTERN_A);
    send_request(CMD_PUSH, 5'd0, PATTERN_B);
    send_request(CMD_PUSH, 5'd0, ALL_ONES);
    send_request(CMD_INSERT, 5'd3, ALL_ONES);
    send_request(CMD_INSERT, 5'd1, ALL_ONES);
    send_request(CMD_PUSH_UNIQ, 5'd0, PATTERN_A);
    // shrinking the capacity below the fill keeps the held entries
    write_capacity(5'd1);
    send_request(CMD_PUSH, 5'd0, ALL_ZEROS);
    send_request(CMD_GET, 5'd1, ALL_ZEROS);

    // random part: three idling regimes, several capacity settings in each
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      case (seg / 3)
        0: begin
          sender_idle_pct   = 21;
          receiver_idle_pct = 53;
        end
        1: begin
          sender_idle_pct   = 53;
          receiver_idle_pct = 21;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      write_capacity(capacity_for_segment(seg));
      for (int i = 0; i < 4; i++) word_pool[i] = random_word();
      repeat (ITEMS_PER_SEGMENT) random_request();
    end

    // wait for every owed result, then watch a little longer for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
